// ----- src/bsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver package
// Shared constants, command codes and channel payload types.
// ----------------------------------------------------------------------------
package bsfr_pkg;

	localparam int unsigned BUFFER_DEPTH = 256;

	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_XOR   = 8'h20;
	localparam int unsigned CRC_BYTES = 2;

	localparam logic CMD_RECEIVE = 1'b0;
	localparam logic CMD_READ    = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic [7:0] read_index;
	} req_t;

	typedef struct packed {
		logic       frame_done;
		logic       message_ready;
		logic [7:0] message_length;
		logic [7:0] read_data;
	} rsp_t;

endpackage

// ----- src/bsfr_stream_if.sv -----
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver stream channel
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface bsfr_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/bsfr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsfr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/byte_stuffed_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver
// Decodes an HDLC-style byte-stuffed stream into a frame buffer and serves
// reads of the completed frame.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on req carries a command. A receive command hands in one raw
// link byte: 0x7D arms an escape, 0x7E closes the frame (dropping the two
// CRC bytes), and any other byte is stored if there is room. A read
// command returns the stored byte at read_index if a ready frame holds
// that index, and zero otherwise. Every req beat produces exactly one rsp
// beat with frame_done, the ready flag, the ready length and the read data.
// An accepted req beat passes through stage one (the buffer read) and then
// the result register before rsp valid. Throughput is one beat per cycle
// while rsp does not stall, set by the state update and the one write /
// one read port of the frame buffer.
// Two slots sit between the sides, so req keeps being taken after rsp
// stalls until both slots hold a beat; then req.ready drops until rsp drains.
// Reset clears the fill count, the ready flag, the escape flag and the
// result slots. Buffer contents are not cleared; only written bytes are read.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver #(
	parameter int unsigned BUFFER_DEPTH = bsfr_pkg::BUFFER_DEPTH
) (
	input logic           clk,
	input logic           arst_n,
	bsfr_stream_if.sink   req,
	bsfr_stream_if.source rsp
);

	localparam int unsigned AW   = $clog2(BUFFER_DEPTH);
	localparam int unsigned CW   = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned IW   = (AW > 8) ? AW : 8;
	localparam int unsigned CMPW = (IW > CW) ? IW : CW;
	localparam int unsigned LW   = (CW > 9) ? CW : 9;

	typedef struct packed {
		logic       frame_done;
		logic       message_ready;
		logic [7:0] message_length;
		logic       read_hit;
	} meta_t;

	// Receiver state
	logic [CW-1:0] fill_q;
	logic          ready_q;
	logic          esc_q;

	// Stage after acceptance (buffer read in flight) and the result slot
	logic          valid_s1;
	meta_t         meta_s1;
	logic          out_valid_q;
	bsfr_pkg::rsp_t out_q;

	logic          accept;
	logic          adv_s1;
	logic          is_rx;

	logic [CW-1:0] fill_base;
	logic          esc_base;
	logic [CW-1:0] fill_d;
	logic          ready_d;
	logic          esc_d;
	logic          done_d;
	logic          wr_en;
	logic [7:0]    wr_data;
	logic [AW-1:0] wr_addr;

	logic [IW-1:0]   idx_w;
	logic [AW-1:0]   rd_addr;
	logic            rd_hit;
	logic [7:0]      rd_data;
	logic [LW-1:0]   fill_len;
	logic [7:0]      len_d;
	meta_t           meta_d;

	assign adv_s1    = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign accept    = req.valid && req.ready;
	assign is_rx     = (req.data.cmd == bsfr_pkg::CMD_RECEIVE);

	// Next receiver state for a receive beat.
	always_comb begin
		fill_base = ready_q ? '0 : fill_q;
		esc_base  = ready_q ? 1'b0 : esc_q;
		fill_d    = fill_base;
		esc_d     = esc_base;
		ready_d   = 1'b0;
		done_d    = 1'b0;
		wr_en     = 1'b0;
		wr_data   = req.data.rx_byte ^ (esc_base ? bsfr_pkg::ESC_XOR : 8'h00);
		wr_addr   = fill_base[AW-1:0];
		if (req.data.rx_byte == bsfr_pkg::FLAG_BYTE) begin
			esc_d = 1'b0;
			if (fill_base > CW'(bsfr_pkg::CRC_BYTES)) begin
				fill_d  = fill_base - CW'(bsfr_pkg::CRC_BYTES);
				ready_d = 1'b1;
				done_d  = 1'b1;
			end else begin
				fill_d = '0;
			end
		end else if (req.data.rx_byte == bsfr_pkg::ESC_BYTE) begin
			esc_d = 1'b1;
		end else if (fill_base < CW'(BUFFER_DEPTH)) begin
			// Full buffer drops the byte and leaves a pending escape armed.
			wr_en  = 1'b1;
			fill_d = fill_base + CW'(1);
			esc_d  = 1'b0;
		end
	end

	// Read path and the result fields that follow from the state after this beat.
	always_comb begin
		idx_w   = IW'(req.data.read_index);
		rd_addr = idx_w[AW-1:0];
		rd_hit  = !is_rx && ready_q && (CMPW'(idx_w) < CMPW'(fill_q));
		if (is_rx) begin
			fill_len = LW'(fill_d);
			meta_d.frame_done    = done_d;
			meta_d.message_ready = ready_d;
		end else begin
			fill_len = LW'(fill_q);
			meta_d.frame_done    = 1'b0;
			meta_d.message_ready = ready_q;
		end
		len_d = (fill_len > LW'(255)) ? 8'hFF : fill_len[7:0];
		meta_d.message_length = meta_d.message_ready ? len_d : 8'h00;
		meta_d.read_hit       = rd_hit;
	end

	bsfr_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && is_rx && wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (accept && !is_rx),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ready_q <= 1'b0;
			esc_q   <= 1'b0;
		end else if (accept && is_rx) begin
			fill_q  <= fill_d;
			ready_q <= ready_d;
			esc_q   <= esc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers; the buffer read data holds while the beat waits in stage one.
	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_d;
		end
		if (adv_s1) begin
			out_q.frame_done     <= meta_s1.frame_done;
			out_q.message_ready  <= meta_s1.message_ready;
			out_q.message_length <= meta_s1.message_length;
			out_q.read_data      <= meta_s1.read_hit ? rd_data : 8'h00;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

// ----- dv/bsfr_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver checker
// Watches the req and rsp channels. It decodes every accepted req beat with
// its own copy of the deframer state, queues the expected response, and
// compares each accepted rsp beat field by field with the oldest entry.
// ----------------------------------------------------------------------------
module bsfr_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	bsfr_stream_if      req,
	bsfr_stream_if      rsp,
	output int unsigned mismatch_count,
	output int unsigned results_pending
);

	logic [7:0]     frame_bytes [bsfr_pkg::BUFFER_DEPTH];
	int unsigned    held_count;
	logic           held_ready;
	logic           escape_armed;
	int unsigned    error_total;
	bsfr_pkg::rsp_t expected_q [$];

	// Advances the deframer state by one beat and returns the response it gives.
	function automatic bsfr_pkg::rsp_t decode_beat(bsfr_pkg::req_t beat);
		bsfr_pkg::rsp_t res;
		res = '0;
		if (beat.cmd == bsfr_pkg::CMD_RECEIVE) begin
			if (held_ready) begin
				held_count   = 0;
				held_ready   = 1'b0;
				escape_armed = 1'b0;
			end
			if (beat.rx_byte == bsfr_pkg::FLAG_BYTE) begin
				escape_armed = 1'b0;
				if (held_count > bsfr_pkg::CRC_BYTES) begin
					held_count     = held_count - bsfr_pkg::CRC_BYTES;
					held_ready     = 1'b1;
					res.frame_done = 1'b1;
				end else begin
					held_count = 0;
				end
			end else if (beat.rx_byte == bsfr_pkg::ESC_BYTE) begin
				escape_armed = 1'b1;
			end else if (held_count < bsfr_pkg::BUFFER_DEPTH) begin
				// A byte dropped on a full buffer leaves the escape armed.
				frame_bytes[held_count] = escape_armed ?
					(beat.rx_byte ^ bsfr_pkg::ESC_XOR) : beat.rx_byte;
				held_count   = held_count + 1;
				escape_armed = 1'b0;
			end
		end else if (held_ready && beat.read_index < held_count) begin
			res.read_data = frame_bytes[beat.read_index];
		end
		res.message_ready  = held_ready;
		res.message_length = !held_ready ? 8'd0 : (held_count > 255) ? 8'd255 : 8'(held_count);
		return res;
	endfunction

	function automatic int unsigned field_mismatch(string field, logic [7:0] want,
			logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		bsfr_pkg::rsp_t want;
		bsfr_pkg::rsp_t got;
		if (!arst_n) begin
			held_count   = 0;
			held_ready   = 1'b0;
			escape_armed = 1'b0;
			error_total  = 0;
			expected_q.delete();
			mismatch_count  <= 0;
			results_pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (expected_q.size() == 0) begin
					$display("%0t ns: unexpected response beat, expected none, actual %h",
						$time, got);
					error_total++;
				end else begin
					want = expected_q.pop_front();
					error_total += field_mismatch("frame_done", 8'(want.frame_done),
						8'(got.frame_done));
					error_total += field_mismatch("message_ready", 8'(want.message_ready),
						8'(got.message_ready));
					error_total += field_mismatch("message_length", want.message_length,
						got.message_length);
					error_total += field_mismatch("read_data", want.read_data, got.read_data);
				end
			end
			if (req.valid && req.ready)
				expected_q.push_back(decode_beat(req.data));
			mismatch_count  <= error_total;
			results_pending <= expected_q.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-stuffed frame receiver testbench
// Drives directed and random stuffed byte streams and frame reads into the
// receiver under several idle and stall patterns, and reports the verdict
// of the checker that runs beside it.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned RANDOM_ITEMS = 1350;
	localparam int unsigned PHASE_ITEMS  = RANDOM_ITEMS / 4;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned beats_sent;
	int unsigned last_length;
	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned results_pending;

	bsfr_stream_if #(.payload_t(bsfr_pkg::req_t)) req_ch ();
	bsfr_stream_if #(.payload_t(bsfr_pkg::rsp_t)) rsp_ch ();

	byte_stuffed_frame_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bsfr_frame_checker deframe_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** byte_stuffed_frame_receiver: FAILED **");
		$finish;
	end

	// Biased so that flag and escape bytes turn up often.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return bsfr_pkg::FLAG_BYTE;
			1: return bsfr_pkg::ESC_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int unsigned frame_size();
		return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 60);
	endfunction

	task automatic send_beat(bsfr_pkg::req_t item);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= item;
		do @(posedge clk); while (!req_ch.ready);
		beats_sent++;
	endtask

	task automatic send_rx(logic [7:0] value);
		bsfr_pkg::req_t item;
		item.cmd        = bsfr_pkg::CMD_RECEIVE;
		item.rx_byte    = value;
		item.read_index = 8'($urandom_range(0, 255));
		send_beat(item);
	endtask

	task automatic send_read(logic [7:0] index);
		bsfr_pkg::req_t item;
		item.cmd        = bsfr_pkg::CMD_READ;
		item.rx_byte    = 8'($urandom_range(0, 255));
		item.read_index = index;
		send_beat(item);
	endtask

	// Sends one data byte, stuffed when it collides with a control byte.
	task automatic send_payload(logic [7:0] value);
		if (value == bsfr_pkg::FLAG_BYTE || value == bsfr_pkg::ESC_BYTE) begin
			send_rx(bsfr_pkg::ESC_BYTE);
			send_rx(value ^ bsfr_pkg::ESC_XOR);
		end else begin
			send_rx(value);
		end
	endtask

	task automatic send_frame(int unsigned payload_len);
		for (int unsigned i = 0; i < payload_len + bsfr_pkg::CRC_BYTES; i++)
			send_payload(pick_byte());
		send_rx(bsfr_pkg::FLAG_BYTE);
		last_length = (payload_len > bsfr_pkg::BUFFER_DEPTH - bsfr_pkg::CRC_BYTES) ?
			bsfr_pkg::BUFFER_DEPTH - bsfr_pkg::CRC_BYTES : payload_len;
	endtask

	task automatic read_burst();
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 1) != 0)
				send_read(8'($urandom_range(0, last_length + 1)));
			else
				send_read(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	initial begin
		int unsigned phase_goal;
		int unsigned kind;
		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.data    <= '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		beats_sent     = 0;
		last_length    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reads with nothing held, then a flag on an empty buffer.
		send_read(8'd0);
		send_read(8'd255);
		send_rx(bsfr_pkg::FLAG_BYTE);
		// Extreme and stuffed bytes, closed with a two byte CRC slot.
		send_rx(8'h00);
		send_rx(8'hFF);
		send_payload(bsfr_pkg::FLAG_BYTE);
		send_payload(bsfr_pkg::ESC_BYTE);
		send_rx(8'hAA);
		send_rx(8'h55);
		send_rx(bsfr_pkg::FLAG_BYTE);
		send_read(8'd0);
		send_read(8'd3);
		send_read(8'd4);
		// A byte after a ready frame clears it; a flag after an escape clears the escape and drops the one-byte frame.
		send_rx(8'h11);
		send_rx(bsfr_pkg::ESC_BYTE);
		send_rx(bsfr_pkg::FLAG_BYTE);
		// A repeated escape stays armed for the next data byte.
		send_rx(bsfr_pkg::ESC_BYTE);
		send_rx(bsfr_pkg::ESC_BYTE);
		send_rx(8'h01);
		send_rx(8'h02);
		send_rx(8'h03);
		send_rx(bsfr_pkg::FLAG_BYTE);
		send_read(8'd0);
		// Two bytes then a flag is too short to be a frame.
		send_rx(8'h22);
		send_rx(8'h33);
		send_rx(bsfr_pkg::FLAG_BYTE);
		drain_results();

		for (int unsigned phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			phase_goal = beats_sent + PHASE_ITEMS;
			// Send a frame near or past the buffer size once in the first and last phase.
			if (phase == 0 || phase == 3) begin
				send_frame($urandom_range(bsfr_pkg::BUFFER_DEPTH - 4,
					bsfr_pkg::BUFFER_DEPTH + 6));
				read_burst();
				send_read(8'd253);
				send_read(8'd254);
			end
			while (beats_sent < phase_goal) begin
				kind = $urandom_range(0, 99);
				if (kind < 55) begin
					send_frame(frame_size());
					read_burst();
				end else if (kind < 70) begin
					read_burst();
				end else if (kind < 85) begin
					repeat ($urandom_range(1, 8)) send_rx(pick_byte());
				end else begin
					case ($urandom_range(0, 2))
						0: begin
							repeat ($urandom_range(0, 2)) send_payload(pick_byte());
							send_rx(bsfr_pkg::FLAG_BYTE);
						end
						1: begin
							repeat ($urandom_range(1, 4)) send_payload(pick_byte());
							send_rx(bsfr_pkg::ESC_BYTE);
							send_rx(bsfr_pkg::FLAG_BYTE);
						end
						default: begin
							send_rx(bsfr_pkg::ESC_BYTE);
							send_rx(bsfr_pkg::ESC_BYTE);
							send_frame(frame_size());
							read_burst();
						end
					endcase
				end
			end
			drain_results();
		end

		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("** byte_stuffed_frame_receiver: PASSED **");
		else
			$display("** byte_stuffed_frame_receiver: FAILED **");
		$finish;
	end

endmodule
